/* rtl/wva_pkg.sv */
// ----------------------------------------------------------------------------
// wva_pkg
// Shared types and constants of the wind vector averager: field widths,
// heading codes, CORDIC arctangent table and the control state type.
// ----------------------------------------------------------------------------
package wva_pkg;

	// window limits
	localparam int MAX_SAMPLES  = 1024;
	localparam int TALLY_W      = $clog2(MAX_SAMPLES + 1);

	// cordic
	localparam int CORDIC_STEPS = 16;
	localparam int ATAN_LEN     = 24;
	localparam int CORDIC_RUN   = (CORDIC_STEPS < ATAN_LEN) ? CORDIC_STEPS : ATAN_LEN;
	localparam int STEP_W       = $clog2(ATAN_LEN);
	localparam int CW           = 36;
	localparam logic signed [CW-1:0] CORDIC_GAIN = 36'sd652032874;
	localparam logic [30:0] TRIG_ONE = 31'h4000_0000;

	localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
		32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
		32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
		32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163, 32'd81
	};

	// heading codes, 0.01 degree
	localparam logic [15:0] HEAD_NORTH = 16'd0;
	localparam logic [15:0] HEAD_EAST  = 16'd9000;
	localparam logic [15:0] HEAD_SOUTH = 16'd18000;
	localparam logic [15:0] HEAD_WEST  = 16'd27000;
	localparam logic [15:0] HEAD_MOD   = 16'd36000;
	localparam logic [31:0] ANGLE_BIAS = 32'd18000;

	// serial divider
	localparam int DIV_W   = 48;
	localparam int DVS_W   = 17;
	localparam int DCNT_W  = $clog2(DIV_W);

	// serial square root
	localparam int SQ_W    = 48;
	localparam int ROOT_W  = SQ_W / 2;
	localparam int RCNT_W  = $clog2(ROOT_W);

	// accumulator and component widths
	localparam int SUM_W   = 34;
	localparam int COMP_W  = 24;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_QUAD,
		ST_ANG,
		ST_ROT,
		ST_MUL_E,
		ST_MUL_N,
		ST_ACC,
		ST_MEAN_E_GO,
		ST_MEAN_E,
		ST_MEAN_N_GO,
		ST_MEAN_N,
		ST_SQ_E,
		ST_SQ_N,
		ST_ROOT_GO,
		ST_ROOT,
		ST_HEAD,
		ST_VEC,
		ST_HMUL,
		ST_OUT
	} wva_state_t;

endpackage

/* rtl/wva_if.sv */
// ----------------------------------------------------------------------------
// wva_if
// Valid/ready channels of the wind vector averager: sample in, result out.
// ----------------------------------------------------------------------------
interface wva_sample_if;
	logic        valid;
	logic        ready;
	logic [15:0] speed;
	logic [15:0] heading;
	logic        last_sample;

	modport source (output valid, speed, heading, last_sample, input ready);
	modport sink   (input valid, speed, heading, last_sample, output ready);
endinterface

interface wva_result_if;
	logic               valid;
	logic               ready;
	logic        [15:0] mean_speed;
	logic        [15:0] mean_heading;
	logic signed [23:0] mean_east;
	logic signed [23:0] mean_north;
	logic        [10:0] samples_used;
	logic               overflowed;

	modport source (output valid, mean_speed, mean_heading, mean_east, mean_north,
		samples_used, overflowed, input ready);
	modport sink   (input valid, mean_speed, mean_heading, mean_east, mean_north,
		samples_used, overflowed, output ready);
endinterface

/* rtl/wva_divider.sv */
// ----------------------------------------------------------------------------
// wva_divider
// Restoring divider, one quotient bit per cycle. The dividend shifts out at
// the top while quotient bits shift in at the bottom of the same register.
// ----------------------------------------------------------------------------
module wva_divider (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [wva_pkg::DIV_W-1:0]      dividend,
	input  logic [wva_pkg::DVS_W-1:0]      divisor,
	output logic                           done,
	output logic [wva_pkg::DIV_W-1:0]      quotient
);

	logic                          busy_q;
	logic                          done_q;
	logic [wva_pkg::DCNT_W-1:0]    cnt_q;
	logic [wva_pkg::DIV_W-1:0]     shf_q;
	logic [wva_pkg::DVS_W-1:0]     rem_q;
	logic [wva_pkg::DVS_W-1:0]     dvs_q;
	logic [wva_pkg::DVS_W:0]       trial;
	logic                          fits;

	// one trial subtraction per cycle
	always_comb begin
		trial = {rem_q, shf_q[wva_pkg::DIV_W-1]};
		fits  = (trial >= {1'b0, dvs_q});
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == wva_pkg::DCNT_W'(wva_pkg::DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			shf_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			shf_q <= {shf_q[wva_pkg::DIV_W-2:0], fits};
			rem_q <= fits ? wva_pkg::DVS_W'(trial - {1'b0, dvs_q})
			              : wva_pkg::DVS_W'(trial);
		end
	end

	assign done     = done_q;
	assign quotient = shf_q;

endmodule

/* rtl/wva_cordic.sv */
// ----------------------------------------------------------------------------
// wva_cordic
// Iterative CORDIC, one micro-rotation per cycle, shared between rotation
// mode (sine and cosine of a heading) and vectoring mode (angle of a vector).
// ----------------------------------------------------------------------------
module wva_cordic (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic                              vectoring,
	input  logic signed [wva_pkg::CW-1:0]     x0,
	input  logic signed [wva_pkg::CW-1:0]     y0,
	input  logic signed [wva_pkg::CW-1:0]     z0,
	output logic                              done,
	output logic signed [wva_pkg::CW-1:0]     x,
	output logic signed [wva_pkg::CW-1:0]     y,
	output logic signed [wva_pkg::CW-1:0]     z
);

	logic                            busy_q;
	logic                            done_q;
	logic                            vec_q;
	logic [wva_pkg::STEP_W-1:0]      idx_q;
	logic signed [wva_pkg::CW-1:0]   x_q;
	logic signed [wva_pkg::CW-1:0]   y_q;
	logic signed [wva_pkg::CW-1:0]   z_q;
	logic signed [wva_pkg::CW-1:0]   dx;
	logic signed [wva_pkg::CW-1:0]   dy;
	logic signed [wva_pkg::CW-1:0]   ang;
	logic                            down;

	// micro-rotation terms
	always_comb begin
		dx   = y_q >>> idx_q;
		dy   = x_q >>> idx_q;
		ang  = $signed({4'b0, wva_pkg::ATAN_TAB[idx_q]});
		down = vec_q ? y_q[wva_pkg::CW-1] : !z_q[wva_pkg::CW-1];
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			idx_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (busy_q) begin
				idx_q <= idx_q + 1'b1;
				if (idx_q == wva_pkg::STEP_W'(wva_pkg::CORDIC_RUN - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= x0;
			y_q   <= y0;
			z_q   <= z0;
			vec_q <= vectoring;
		end else if (busy_q) begin
			if (down) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - ang;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + ang;
			end
		end
	end

	assign done = done_q;
	assign x    = x_q;
	assign y    = y_q;
	assign z    = z_q;

endmodule

/* rtl/wva_isqrt.sv */
// ----------------------------------------------------------------------------
// wva_isqrt
// Digit-by-digit integer square root, rounding down: two radicand bits and
// one root bit per cycle.
// ----------------------------------------------------------------------------
module wva_isqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [wva_pkg::SQ_W-1:0]      radicand,
	output logic                          done,
	output logic [wva_pkg::ROOT_W-1:0]    root
);

	logic                          busy_q;
	logic                          done_q;
	logic [wva_pkg::RCNT_W-1:0]    cnt_q;
	logic [wva_pkg::SQ_W-1:0]      v_q;
	logic [wva_pkg::ROOT_W+2:0]    rem_q;
	logic [wva_pkg::ROOT_W-1:0]    root_q;
	logic [wva_pkg::ROOT_W+2:0]    rem_in;
	logic [wva_pkg::ROOT_W+2:0]    trial;
	logic                          fits;

	// next digit trial
	always_comb begin
		rem_in = {rem_q[wva_pkg::ROOT_W:0], v_q[wva_pkg::SQ_W-1 -: 2]};
		trial  = (wva_pkg::ROOT_W+3)'({root_q, 2'b01});
		fits   = (rem_in >= trial);
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == wva_pkg::RCNT_W'(wva_pkg::ROOT_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			v_q    <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			v_q    <= {v_q[wva_pkg::SQ_W-3:0], 2'b00};
			rem_q  <= fits ? rem_in - trial : rem_in;
			root_q <= {root_q[wva_pkg::ROOT_W-2:0], fits};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

/* rtl/wind_vector_averager_core.sv */
// ----------------------------------------------------------------------------
// wind_vector_averager_core
// Vector averaging of wind speed and compass heading over a window of samples.
// ----------------------------------------------------------------------------
// Each accepted sample is split into east and north components by an
// iterative CORDIC and added into saturating 34-bit sums; a sample marked
// last closes the window and produces one result (mean components, speed,
// heading, sample count, overflow flag), after which the sums clear. Work is
// serial: a sample passes through the 48-step bit-serial divider that forms
// the binary angle and the 16-step CORDIC; closing a window adds two 48-step
// mean divisions, a 24-step square root and, unless the mean lies on an axis,
// a second CORDIC pass. One sample is in work at a time;
// the next is taken once the previous one is done, while a finished result
// may still wait in the output register. Samples beyond the window limit are
// dropped and flag the result.
module wind_vector_averager_core (
	input  logic                clk,
	input  logic                arst_n,
	wva_sample_if.sink          sample,
	wva_result_if.source        result
);

	wva_pkg::wva_state_t state_q, state_d;

	// sample registers
	logic [15:0]                         speed_q;
	logic [15:0]                         hd_q;
	logic                                last_q;
	logic [1:0]                          quad_q;
	logic [30:0]                         sn_q;
	logic [30:0]                         cs_q;
	logic [23:0]                         mag_e_q;
	logic [23:0]                         mag_n_q;

	// window state
	logic signed [wva_pkg::SUM_W-1:0]    east_sum_q;
	logic signed [wva_pkg::SUM_W-1:0]    north_sum_q;
	logic [wva_pkg::TALLY_W-1:0]         tally_q;
	logic                                ovf_q;

	// window result
	logic signed [wva_pkg::COMP_W-1:0]   me_q;
	logic signed [wva_pkg::COMP_W-1:0]   mn_q;
	logic [wva_pkg::SQ_W-1:0]            sq_q;
	logic [15:0]                         spd_q;
	logic [15:0]                         head_q;
	logic [31:0]                         ang_q;

	// output register
	logic                                out_valid_q;
	logic [15:0]                         o_speed_q;
	logic [15:0]                         o_head_q;
	logic signed [23:0]                  o_east_q;
	logic signed [23:0]                  o_north_q;
	logic [10:0]                         o_used_q;
	logic                                o_ovf_q;

	// control strobes
	logic accept;
	logic div_start;
	logic cordic_start;
	logic cordic_vec;
	logic root_start;
	logic out_load;

	// unit connections
	logic                                div_done;
	logic [wva_pkg::DIV_W-1:0]           div_dvd;
	logic [wva_pkg::DVS_W-1:0]           div_dvs;
	logic [wva_pkg::DIV_W-1:0]           div_quo;
	logic                                cor_done;
	logic signed [wva_pkg::CW-1:0]       cor_x0, cor_y0, cor_z0;
	logic signed [wva_pkg::CW-1:0]       cor_x, cor_y, cor_z;
	logic                                root_done;
	logic [wva_pkg::ROOT_W-1:0]          root_val;

	// datapath helpers
	logic                                room;
	logic [1:0]                          quad_w;
	logic [15:0]                         resid_w;
	logic [30:0]                         sn_w, cs_w;
	logic [30:0]                         trig_w;
	logic [46:0]                         prod_w;
	logic                                neg_e, neg_n;
	logic signed [wva_pkg::SUM_W:0]      e_add, n_add;
	logic [wva_pkg::SUM_W:0]             abs_w;
	logic [23:0]                         q_mag;
	logic signed [47:0]                  sq_w;
	logic [24:0]                         rnd_w;
	logic                                axis;
	logic                                flip;
	logic signed [wva_pkg::CW-1:0]       vx, vy;
	logic [48:0]                         hprod_w;
	logic [16:0]                         hraw_w;

	function automatic logic [30:0] clamp_q30(input logic signed [wva_pkg::CW-1:0] v);
		logic [30:0] r;
		if (v[wva_pkg::CW-1])
			r = '0;
		else if (v > $signed({5'b0, wva_pkg::TRIG_ONE}))
			r = wva_pkg::TRIG_ONE;
		else
			r = v[30:0];
		return r;
	endfunction

	function automatic logic signed [wva_pkg::SUM_W-1:0] sat_sum(
		input logic signed [wva_pkg::SUM_W:0] v);
		logic signed [wva_pkg::SUM_W-1:0] r;
		if (v[wva_pkg::SUM_W] != v[wva_pkg::SUM_W-1])
			r = v[wva_pkg::SUM_W] ? {1'b1, {(wva_pkg::SUM_W-1){1'b0}}}
			                      : {1'b0, {(wva_pkg::SUM_W-1){1'b1}}};
		else
			r = v[wva_pkg::SUM_W-1:0];
		return r;
	endfunction

	// shared units
	wva_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_quo)
	);

	wva_cordic u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cordic_start),
		.vectoring (cordic_vec),
		.x0        (cor_x0),
		.y0        (cor_y0),
		.z0        (cor_z0),
		.done      (cor_done),
		.x         (cor_x),
		.y         (cor_y),
		.z         (cor_z)
	);

	wva_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (root_start),
		.radicand (sq_q),
		.done     (root_done),
		.root     (root_val)
	);

	// quadrant split and component arithmetic
	always_comb begin
		room = (tally_q < wva_pkg::TALLY_W'(wva_pkg::MAX_SAMPLES));
		if (hd_q >= wva_pkg::HEAD_WEST) begin
			quad_w  = 2'd3;
			resid_w = hd_q - wva_pkg::HEAD_WEST;
		end else if (hd_q >= wva_pkg::HEAD_SOUTH) begin
			quad_w  = 2'd2;
			resid_w = hd_q - wva_pkg::HEAD_SOUTH;
		end else if (hd_q >= wva_pkg::HEAD_EAST) begin
			quad_w  = 2'd1;
			resid_w = hd_q - wva_pkg::HEAD_EAST;
		end else begin
			quad_w  = 2'd0;
			resid_w = hd_q;
		end
		sn_w = clamp_q30(cor_y);
		cs_w = clamp_q30(cor_x);
		// east uses sine in quadrants 0 and 2, north the other one
		if (state_q == wva_pkg::ST_MUL_E)
			trig_w = quad_q[0] ? cs_q : sn_q;
		else
			trig_w = quad_q[0] ? sn_q : cs_q;
		prod_w = 47'(speed_q) * 47'(trig_w) + 47'(23'h40_0000);
		neg_e  = quad_q[1];
		neg_n  = (quad_q == 2'd1) || (quad_q == 2'd2);
		e_add  = {east_sum_q[wva_pkg::SUM_W-1], east_sum_q}
		       + (neg_e ? -$signed({11'b0, mag_e_q}) : $signed({11'b0, mag_e_q}));
		n_add  = {north_sum_q[wva_pkg::SUM_W-1], north_sum_q}
		       + (neg_n ? -$signed({11'b0, mag_n_q}) : $signed({11'b0, mag_n_q}));
		q_mag  = div_quo[23:0];
		sq_w   = (state_q == wva_pkg::ST_SQ_E) ? me_q * me_q : mn_q * mn_q;
		rnd_w  = 25'(root_val) + 25'd64;
		axis   = (me_q == '0) || (mn_q == '0);
		flip   = mn_q[wva_pkg::COMP_W-1];
		vx     = $signed({{4{mn_q[23]}}, mn_q, 8'b0});
		vy     = $signed({{4{me_q[23]}}, me_q, 8'b0});
		hprod_w = 49'(ang_q) * 49'(wva_pkg::HEAD_MOD) + 49'(32'h8000_0000);
		hraw_w  = hprod_w[48:32];
	end

	// divider operand selection
	always_comb begin
		case (state_q)
			wva_pkg::ST_QUAD: begin
				abs_w   = '0;
				div_dvd = {16'(resid_w), wva_pkg::ANGLE_BIAS};
				div_dvs = wva_pkg::DVS_W'(wva_pkg::HEAD_MOD);
			end
			wva_pkg::ST_MEAN_E_GO: begin
				abs_w   = east_sum_q[wva_pkg::SUM_W-1]
				        ? -{east_sum_q[wva_pkg::SUM_W-1], east_sum_q}
				        : {east_sum_q[wva_pkg::SUM_W-1], east_sum_q};
				div_dvd = wva_pkg::DIV_W'(abs_w + (wva_pkg::SUM_W+1)'(tally_q >> 1));
				div_dvs = wva_pkg::DVS_W'(tally_q);
			end
			default: begin
				abs_w   = north_sum_q[wva_pkg::SUM_W-1]
				        ? -{north_sum_q[wva_pkg::SUM_W-1], north_sum_q}
				        : {north_sum_q[wva_pkg::SUM_W-1], north_sum_q};
				div_dvd = wva_pkg::DIV_W'(abs_w + (wva_pkg::SUM_W+1)'(tally_q >> 1));
				div_dvs = wva_pkg::DVS_W'(tally_q);
			end
		endcase
	end

	// cordic operand selection
	always_comb begin
		if (state_q == wva_pkg::ST_HEAD) begin
			cor_x0 = flip ? -vx : vx;
			cor_y0 = flip ? -vy : vy;
			cor_z0 = flip ? $signed(36'h0_8000_0000) : '0;
		end else begin
			cor_x0 = wva_pkg::CORDIC_GAIN;
			cor_y0 = '0;
			cor_z0 = $signed({4'b0, div_quo[31:0]});
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			wva_pkg::ST_IDLE: begin
				if (sample.valid) begin
					if (room)
						state_d = wva_pkg::ST_QUAD;
					else if (sample.last_sample)
						state_d = wva_pkg::ST_MEAN_E_GO;
				end
			end
			wva_pkg::ST_QUAD:  state_d = wva_pkg::ST_ANG;
			wva_pkg::ST_ANG:   if (div_done) state_d = wva_pkg::ST_ROT;
			wva_pkg::ST_ROT:   if (cor_done) state_d = wva_pkg::ST_MUL_E;
			wva_pkg::ST_MUL_E: state_d = wva_pkg::ST_MUL_N;
			wva_pkg::ST_MUL_N: state_d = wva_pkg::ST_ACC;
			wva_pkg::ST_ACC:   state_d = last_q ? wva_pkg::ST_MEAN_E_GO : wva_pkg::ST_IDLE;
			wva_pkg::ST_MEAN_E_GO: state_d = wva_pkg::ST_MEAN_E;
			wva_pkg::ST_MEAN_E: if (div_done) state_d = wva_pkg::ST_MEAN_N_GO;
			wva_pkg::ST_MEAN_N_GO: state_d = wva_pkg::ST_MEAN_N;
			wva_pkg::ST_MEAN_N: if (div_done) state_d = wva_pkg::ST_SQ_E;
			wva_pkg::ST_SQ_E:  state_d = wva_pkg::ST_SQ_N;
			wva_pkg::ST_SQ_N:  state_d = wva_pkg::ST_ROOT_GO;
			wva_pkg::ST_ROOT_GO: state_d = wva_pkg::ST_ROOT;
			wva_pkg::ST_ROOT:  if (root_done) state_d = wva_pkg::ST_HEAD;
			wva_pkg::ST_HEAD:  state_d = axis ? wva_pkg::ST_OUT : wva_pkg::ST_VEC;
			wva_pkg::ST_VEC:   if (cor_done) state_d = wva_pkg::ST_HMUL;
			wva_pkg::ST_HMUL:  state_d = wva_pkg::ST_OUT;
			wva_pkg::ST_OUT:   if (!out_valid_q || result.ready) state_d = wva_pkg::ST_IDLE;
			default:           state_d = wva_pkg::ST_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		sample.ready = (state_q == wva_pkg::ST_IDLE);
		accept       = sample.valid && (state_q == wva_pkg::ST_IDLE);
		div_start    = (state_q == wva_pkg::ST_QUAD) || (state_q == wva_pkg::ST_MEAN_E_GO)
		            || (state_q == wva_pkg::ST_MEAN_N_GO);
		cordic_start = ((state_q == wva_pkg::ST_ANG) && div_done)
		            || ((state_q == wva_pkg::ST_HEAD) && !axis);
		cordic_vec   = (state_q == wva_pkg::ST_HEAD);
		root_start   = (state_q == wva_pkg::ST_ROOT_GO);
		out_load     = (state_q == wva_pkg::ST_OUT) && (!out_valid_q || result.ready);
	end

	// state register, window state and output handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wva_pkg::ST_IDLE;
			east_sum_q  <= '0;
			north_sum_q <= '0;
			tally_q     <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && !room)
				ovf_q <= 1'b1;
			if (state_q == wva_pkg::ST_ACC) begin
				east_sum_q  <= sat_sum(e_add);
				north_sum_q <= sat_sum(n_add);
				tally_q     <= tally_q + 1'b1;
			end
			if (out_load) begin
				east_sum_q  <= '0;
				north_sum_q <= '0;
				tally_q     <= '0;
				ovf_q       <= 1'b0;
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			speed_q <= sample.speed;
			hd_q    <= (sample.heading >= wva_pkg::HEAD_MOD)
			         ? sample.heading - wva_pkg::HEAD_MOD : sample.heading;
			last_q  <= sample.last_sample;
		end
		if (state_q == wva_pkg::ST_QUAD)
			quad_q <= quad_w;
		if ((state_q == wva_pkg::ST_ROT) && cor_done) begin
			sn_q <= sn_w;
			cs_q <= cs_w;
		end
		if (state_q == wva_pkg::ST_MUL_E)
			mag_e_q <= prod_w[46:23];
		if (state_q == wva_pkg::ST_MUL_N)
			mag_n_q <= prod_w[46:23];
		if ((state_q == wva_pkg::ST_MEAN_E) && div_done)
			me_q <= east_sum_q[wva_pkg::SUM_W-1] ? -$signed(q_mag) : $signed(q_mag);
		if ((state_q == wva_pkg::ST_MEAN_N) && div_done)
			mn_q <= north_sum_q[wva_pkg::SUM_W-1] ? -$signed(q_mag) : $signed(q_mag);
		if (state_q == wva_pkg::ST_SQ_E)
			sq_q <= 48'(sq_w);
		if (state_q == wva_pkg::ST_SQ_N)
			sq_q <= sq_q + 48'(sq_w);
		if ((state_q == wva_pkg::ST_ROOT) && root_done)
			spd_q <= (rnd_w[24:7] > 18'd65535) ? 16'hFFFF : rnd_w[22:7];
		// axis headings are exact
		if (state_q == wva_pkg::ST_HEAD) begin
			if (me_q == '0)
				head_q <= (mn_q[wva_pkg::COMP_W-1]) ? wva_pkg::HEAD_SOUTH : wva_pkg::HEAD_NORTH;
			else if (mn_q == '0)
				head_q <= (me_q[wva_pkg::COMP_W-1]) ? wva_pkg::HEAD_WEST : wva_pkg::HEAD_EAST;
		end
		if ((state_q == wva_pkg::ST_VEC) && cor_done)
			ang_q <= cor_z[31:0];
		if (state_q == wva_pkg::ST_HMUL)
			head_q <= (hraw_w >= 17'(wva_pkg::HEAD_MOD))
			        ? 16'(hraw_w - 17'(wva_pkg::HEAD_MOD)) : hraw_w[15:0];
		if (out_load) begin
			o_speed_q <= spd_q;
			o_head_q  <= head_q;
			o_east_q  <= me_q;
			o_north_q <= mn_q;
			o_used_q  <= 11'(tally_q);
			o_ovf_q   <= ovf_q;
		end
	end

	// result channel
	assign result.valid        = out_valid_q;
	assign result.mean_speed   = o_speed_q;
	assign result.mean_heading = o_head_q;
	assign result.mean_east    = o_east_q;
	assign result.mean_north   = o_north_q;
	assign result.samples_used = o_used_q;
	assign result.overflowed   = o_ovf_q;

endmodule

/* sim/wva_result_checker.sv */
// ----------------------------------------------------------------------------
// wva_result_checker
// Watches the sample and result channels of the wind vector averager,
// predicts each window result in fixed point and compares field by field.
// ----------------------------------------------------------------------------
module wva_result_checker (
	input  logic   clk,
	input  logic   arst_n,
	wva_sample_if  sample,
	wva_result_if  result,
	output int     fail_count,
	output int     pending_count
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic        [15:0] mean_speed;
		logic        [15:0] mean_heading;
		logic signed [23:0] mean_east;
		logic signed [23:0] mean_north;
		logic        [10:0] samples_used;
		logic               overflowed;
	} wind_mean_t;

	localparam longint SUM_HI = 64'sd8589934591;
	localparam longint SUM_LO = -64'sd8589934592;

	// running window state of the predictor
	longint     east_sum;
	longint     north_sum;
	int         window_tally;
	bit         window_ovf;
	wind_mean_t mean_queue [$];

	// sine and cosine of a residual angle below 90 degrees, q30
	function automatic void sin_cos(input longint resid, output longint sn,
		output longint cs);
		longint x, y, z, dx, dy;
		x = longint'(wva_pkg::CORDIC_GAIN);
		y = 0;
		z = ((resid <<< 32) + 18000) / 36000;
		for (int i = 0; i < wva_pkg::CORDIC_RUN; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= longint'(wva_pkg::ATAN_TAB[i]);
			end else begin
				x += dx; y -= dy; z += longint'(wva_pkg::ATAN_TAB[i]);
			end
		end
		if (x < 0) x = 0;
		if (x > (64'sd1 <<< 30)) x = 64'sd1 <<< 30;
		if (y < 0) y = 0;
		if (y > (64'sd1 <<< 30)) y = 64'sd1 <<< 30;
		sn = y;
		cs = x;
	endfunction

	function automatic longint component(input longint spd, input longint trig,
		input bit neg);
		longint m;
		m = (spd * trig + (64'sd1 <<< 22)) >>> 23;
		return neg ? -m : m;
	endfunction

	function automatic longint clamp_sum(input longint s);
		if (s > SUM_HI) return SUM_HI;
		if (s < SUM_LO) return SUM_LO;
		return s;
	endfunction

	function automatic longint window_mean(input longint sum, input longint n);
		longint mag, q;
		mag = (sum < 0) ? -sum : sum;
		q = (mag + n / 2) / n;
		return (sum < 0) ? -q : q;
	endfunction

	function automatic longint unsigned root_floor(input longint unsigned v);
		longint unsigned res, b;
		res = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= res + b) begin
				v -= res + b;
				res = (res >> 1) + b;
			end else begin
				res >>= 1;
			end
			b >>= 2;
		end
		return res;
	endfunction

	// compass heading of the mean vector, 0.01 degree
	function automatic logic [15:0] vector_heading(input longint e, input longint n);
		longint x, y, z, dx, dy;
		longint unsigned a, h;
		if (e == 0 && n == 0) return wva_pkg::HEAD_NORTH;
		if (e == 0) return (n > 0) ? wva_pkg::HEAD_NORTH : wva_pkg::HEAD_SOUTH;
		if (n == 0) return (e > 0) ? wva_pkg::HEAD_EAST : wva_pkg::HEAD_WEST;
		x = n * 256;
		y = e * 256;
		z = 0;
		if (x < 0) begin
			x = -x; y = -y; z = 64'sd1 <<< 31;
		end
		for (int i = 0; i < wva_pkg::CORDIC_RUN; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x += dx; y -= dy; z += longint'(wva_pkg::ATAN_TAB[i]);
			end else begin
				x -= dx; y += dy; z -= longint'(wva_pkg::ATAN_TAB[i]);
			end
		end
		a = longint'(z) & 64'hFFFF_FFFF;
		h = (a * 36000 + (64'd1 << 31)) >> 32;
		if (h >= 36000) h -= 36000;
		return h[15:0];
	endfunction

	// fold one sample into the window; true when the window closes
	function automatic bit accumulate_wind(input logic [15:0] spd_in,
		input logic [15:0] head_in, input bit last, output wind_mean_t m);
		longint hd, sn, cs, ev, nv, me, mn, spd;
		longint unsigned mag;
		hd = longint'(head_in) % 36000;
		if (window_tally < wva_pkg::MAX_SAMPLES) begin
			sin_cos(hd % 9000, sn, cs);
			case (hd / 9000)
				0: begin ev = component(spd_in, sn, 0); nv = component(spd_in, cs, 0); end
				1: begin ev = component(spd_in, cs, 0); nv = component(spd_in, sn, 1); end
				2: begin ev = component(spd_in, sn, 1); nv = component(spd_in, cs, 1); end
				default: begin
					ev = component(spd_in, cs, 1); nv = component(spd_in, sn, 0);
				end
			endcase
			east_sum = clamp_sum(east_sum + ev);
			north_sum = clamp_sum(north_sum + nv);
			window_tally++;
		end else begin
			window_ovf = 1;
		end
		m = '0;
		if (!last) return 0;
		me = window_mean(east_sum, window_tally);
		mn = window_mean(north_sum, window_tally);
		mag = root_floor(longint'(me * me) + longint'(mn * mn));
		spd = (mag + 64) >> 7;
		if (spd > 65535) spd = 65535;
		m.mean_speed   = spd[15:0];
		m.mean_heading = vector_heading(me, mn);
		m.mean_east    = me[23:0];
		m.mean_north   = mn[23:0];
		m.samples_used = window_tally[10:0];
		m.overflowed   = window_ovf;
		east_sum = 0;
		north_sum = 0;
		window_tally = 0;
		window_ovf = 0;
		return 1;
	endfunction

	// predict on every sample transaction, check every result transaction
	always @(posedge clk or negedge arst_n) begin
		wind_mean_t m, want;
		if (!arst_n) begin
			east_sum = 0;
			north_sum = 0;
			window_tally = 0;
			window_ovf = 0;
			fail_count <= 0;
			mean_queue.delete();
		end else begin
			if (sample.valid && sample.ready) begin
				if (accumulate_wind(sample.speed, sample.heading, sample.last_sample, m))
					mean_queue.push_back(m);
			end
			if (result.valid && result.ready) begin
				if (mean_queue.size() == 0) begin
					$error("result transaction with nothing expected");
					fail_count <= fail_count + 1;
				end else begin
					want = mean_queue.pop_front();
					if (result.mean_speed !== want.mean_speed ||
						result.mean_heading !== want.mean_heading ||
						result.mean_east !== want.mean_east ||
						result.mean_north !== want.mean_north ||
						result.samples_used !== want.samples_used ||
						result.overflowed !== want.overflowed)
						fail_count <= fail_count + 1;
					if (result.mean_speed !== want.mean_speed)
						$error("mean_speed expected %0d actual %0d",
							want.mean_speed, result.mean_speed);
					if (result.mean_heading !== want.mean_heading)
						$error("mean_heading expected %0d actual %0d",
							want.mean_heading, result.mean_heading);
					if (result.mean_east !== want.mean_east)
						$error("mean_east expected %0d actual %0d",
							want.mean_east, result.mean_east);
					if (result.mean_north !== want.mean_north)
						$error("mean_north expected %0d actual %0d",
							want.mean_north, result.mean_north);
					if (result.samples_used !== want.samples_used)
						$error("samples_used expected %0d actual %0d",
							want.samples_used, result.samples_used);
					if (result.overflowed !== want.overflowed)
						$error("overflowed expected %0d actual %0d",
							want.overflowed, result.overflowed);
				end
			end
		end
	end

	assign pending_count = mean_queue.size();

endmodule

/* sim/wind_vector_averager_core_tb.sv */
// ----------------------------------------------------------------------------
// wind_vector_averager_core_tb
// Drives windows of wind samples into the averager with random gaps and
// back-pressure; the checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module wind_vector_averager_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 2000000;
	localparam int LONG_HOLD   = 4000;

	logic clk = 0;
	logic arst_n = 0;
	int   fail_count;
	int   pending_count;
	int   cycle_count = 0;
	int   results_seen = 0;
	bit   quiet_sender = 0;
	bit   quiet_receiver = 0;

	wva_sample_if sample ();
	wva_result_if result ();

	wind_vector_averager_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample.sink),
		.result (result.source)
	);

	wva_result_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample        (sample),
		.result        (result),
		.fail_count    (fail_count),
		.pending_count (pending_count)
	);

	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// one sample transaction, then the gap before the next
	task automatic send_sample(input logic [15:0] spd, input logic [15:0] hd,
		input bit last);
		int gap;
		sample.valid <= 1;
		sample.speed <= spd;
		sample.heading <= hd;
		sample.last_sample <= last;
		do @(posedge clk); while (!sample.ready);
		@(negedge clk);
		gap = quiet_sender ? 0 : $urandom_range(0, 18);
		if (gap > 0) begin
			sample.valid <= 0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic send_window(input int len, input bit big_speed);
		logic [15:0] spd, hd;
		for (int i = 0; i < len; i++) begin
			spd = big_speed ? 16'($urandom_range(50000, 65535)) : 16'($urandom);
			// mostly valid compass headings, now and then out of range
			hd = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 35999));
			send_sample(spd, hd, i == len - 1);
		end
	endtask

	// receiver: random hold-off per result, one long hold while samples keep coming
	initial begin
		int n;
		result.ready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (results_seen == 6) n = LONG_HOLD;
			else n = quiet_receiver ? 0 : $urandom_range(0, 18);
			if (n > 0) begin
				result.ready <= 0;
				repeat (n) @(negedge clk);
			end
			result.ready <= 1;
			do @(posedge clk); while (!result.valid);
			results_seen++;
		end
	end

	initial begin
		int len;
		sample.valid = 0;
		sample.speed = 0;
		sample.heading = 0;
		sample.last_sample = 0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed: axes, extremes, cancelling vectors, out-of-range heading
		send_sample(16'd0, 16'd0, 1);
		send_sample(16'd65535, wva_pkg::HEAD_NORTH, 1);
		send_sample(16'd65535, wva_pkg::HEAD_EAST, 1);
		send_sample(16'd65535, wva_pkg::HEAD_SOUTH, 1);
		send_sample(16'd65535, wva_pkg::HEAD_WEST, 1);
		send_sample(16'd65535, 16'd35999, 1);
		send_sample(16'd1, 16'd4500, 1);
		send_sample(16'd65535, 16'hFFFF, 1);
		send_sample(16'd40000, 16'd36000, 1);
		send_sample(16'd1000, wva_pkg::HEAD_NORTH, 0);
		send_sample(16'd1000, wva_pkg::HEAD_SOUTH, 1);
		send_sample(16'd777, wva_pkg::HEAD_EAST, 0);
		send_sample(16'd777, wva_pkg::HEAD_WEST, 1);
		send_sample(16'd65535, 16'd4500, 0);
		send_sample(16'd65535, 16'd4500, 0);
		send_sample(16'd65535, 16'd13500, 1);
		send_sample(16'd12345, 16'd22222, 0);
		send_sample(16'd54321, 16'd31111, 0);
		send_sample(16'd3, 16'd100, 1);

		// pause until every expected result is back
		wait (pending_count == 0);
		@(negedge clk);

		// overflowing window
		send_window(wva_pkg::MAX_SAMPLES + 6, 1);

		// random windows, mostly short
		for (int w = 0; w < 210; w++) begin
			quiet_sender = ($urandom_range(0, 4) == 0);
			quiet_receiver = ($urandom_range(0, 4) == 0);
			case ($urandom_range(0, 9))
				0, 1: len = $urandom_range(7, 20);
				default: len = $urandom_range(1, 3);
			endcase
			send_window(len, $urandom_range(0, 7) == 0);
			if (w == 150) begin
				wait (pending_count == 0);
				@(negedge clk);
			end
		end
		sample.valid <= 0;
		quiet_receiver = 0;

		wait (pending_count == 0);
		repeat (300) @(posedge clk);
		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
